FILE: hdl/htmlesc_pkg.sv
// Shared types, escape strings and the short-word table for the HTML escape filter.
// No dependencies; imported by every module of the block.
package htmlesc_pkg;

	// Longest short word, and the cells needed to see it plus the space before it
	localparam int WORD_COUNT = 20;
	localparam int WORD_MAX   = 5;
	localparam int CHAIN_LEN  = WORD_MAX + 1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_QUOT  = 8'h22;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_LT    = 8'h3c;
	localparam logic [7:0] CHAR_GT    = 8'h3e;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_QUOT,
		KIND_AMP,
		KIND_GT,
		KIND_LT,
		KIND_NBSP
	} kind_t;

	typedef struct packed {
		logic       is_space;
		logic       is_letter;
		logic [7:0] low;
	} attr_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	// Words stored left-aligned, first letter in the top byte
	localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd5, 3'd3, 3'd3, 3'd3, 3'd4
	};

	localparam logic [WORD_MAX*8-1:0] WORD_TXT [WORD_COUNT] = '{
		{"v", 32'h0}, {"k", 32'h0}, {"s", 32'h0}, {"a", 32'h0},
		{"u", 32'h0}, {"i", 32'h0}, {"o", 32'h0}, {"z", 32'h0},
		{"na", 24'h0}, {"ve", 24'h0}, {"do", 24'h0}, {"za", 24'h0},
		{"se", 24'h0}, {"po", 24'h0}, {"ke", 24'h0},
		"zpoza", {"pro", 16'h0}, {"nad", 16'h0}, {"pod", 16'h0}, {"pred", 8'h0}
	};

	function automatic logic [7:0] word_char(input int w, input int k);
		return WORD_TXT[w][8*(WORD_MAX-1-k) +: 8];
	endfunction

	function automatic logic [2:0] esc_len(input kind_t kind);
		case (kind)
			KIND_PLAIN: return 3'd1;
			KIND_QUOT:  return 3'd6;
			KIND_AMP:   return 3'd5;
			KIND_GT:    return 3'd4;
			KIND_LT:    return 3'd4;
			KIND_NBSP:  return 3'd6;
			default:    return 3'd1;
		endcase
	endfunction

	// Character idx of an escape sequence, strings left-aligned in 48 bits
	function automatic logic [7:0] esc_char(input kind_t kind, input logic [2:0] idx);
		logic [47:0] s;
		case (kind)
			KIND_QUOT: s = "&quot;";
			KIND_AMP:  s = {"&amp;", 8'h0};
			KIND_GT:   s = {"&gt;", 16'h0};
			KIND_LT:   s = {"&lt;", 16'h0};
			KIND_NBSP: s = "&nbsp;";
			default:   s = 48'h0;
		endcase
		return s[8*(5-int'(idx)) +: 8];
	endfunction

endpackage

FILE: hdl/htmlesc_cell.sv
// One history cell: holds a past byte, shifts it on to the next cell on each accepted word,
// and exposes its space/letter class. Depends on htmlesc_pkg.
module htmlesc_cell
	import htmlesc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] d,
	output logic [7:0] q,
	output attr_t      attr
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (advance) begin
			byte_q <= d;
		end
	end

	always_comb begin
		attr.is_space  = (byte_q == CHAR_SPACE);
		attr.is_letter = 1'b0;
		attr.low       = byte_q;
		if (byte_q inside {[8'h41:8'h5a]}) begin
			attr.is_letter = 1'b1;
			attr.low       = byte_q + 8'd32;
		end else if (byte_q inside {[8'h61:8'h7a]}) begin
			attr.is_letter = 1'b1;
		end
	end

	assign q = byte_q;

endmodule

FILE: hdl/htmlesc_class.sv
// Classifies the incoming byte: escape kind, or non-breaking space when the cell chain
// holds a short word preceded by a space. Depends on htmlesc_pkg.
module htmlesc_class
	import htmlesc_pkg::*;
(
	input  logic [7:0] in_byte,
	input  attr_t      attr [CHAIN_LEN],
	output item_t      item
);

	logic nbsp_hit;

	// Cell 0 holds the previous byte, i.e. the last letter of a word
	always_comb begin : match_l
		logic ok;
		nbsp_hit = 1'b0;
		for (int w = 0; w < WORD_COUNT; w++) begin
			ok = attr[WORD_LEN[w]].is_space;
			for (int d = 0; d < WORD_MAX; d++) begin
				if (d < int'(WORD_LEN[w])) begin
					ok = ok && attr[d].is_letter &&
						(attr[d].low == word_char(w, int'(WORD_LEN[w]) - 1 - d));
				end
			end
			nbsp_hit = nbsp_hit | ok;
		end
	end

	always_comb begin
		item.data = in_byte;
		case (in_byte)
			CHAR_QUOT: item.kind = KIND_QUOT;
			CHAR_AMP:  item.kind = KIND_AMP;
			CHAR_GT:   item.kind = KIND_GT;
			CHAR_LT:   item.kind = KIND_LT;
			CHAR_SPACE: item.kind = nbsp_hit ? KIND_NBSP : KIND_PLAIN;
			default:   item.kind = KIND_PLAIN;
		endcase
	end

endmodule

FILE: hdl/htmlesc_emit.sv
// Two-entry output side: an input holding stage and an output stage that expands an
// escape into its character run. Depends on htmlesc_pkg.
module htmlesc_emit
	import htmlesc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  item_t      item,
	output logic       hold,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	item_t      item_q;
	logic [2:0] idx_q;
	logic       out_fire;
	logic       out_done;
	logic       out_free;
	logic       move_s1;

	assign last     = (idx_q == esc_len(item_q.kind) - 3'd1);
	assign out_fire = out_valid_q && !out_stall;
	assign out_done = out_fire && last;
	assign out_free = !out_valid_q || out_done;
	assign move_s1  = valid_s1 && out_free;
	assign hold     = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (out_done) begin
				out_valid_q <= 1'b0;
			end else if (out_fire) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item;
		end
		if (move_s1) begin
			item_q <= item_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = (item_q.kind == KIND_PLAIN) ? item_q.data : esc_char(item_q.kind, idx_q);

`ifndef ASSERT_OFF
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (idx_q < esc_len(item_q.kind)))
		else $error("escape index beyond run length");
	a_plain_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && item_q.kind == KIND_PLAIN) |-> last)
		else $error("plain word not marked last");
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> (out_valid_q && idx_q == 3'd0))
		else $error("new run did not start at index zero");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move_s1) |=> valid_s1)
		else $error("held word lost");
`endif

endmodule

FILE: hdl/html_escape_nbsp_filter_core.sv
// Top level of the HTML escape filter: history cell chain, classifier and output expander.
// Depends on htmlesc_pkg, htmlesc_cell, htmlesc_class and htmlesc_emit.
//
// Takes one text byte per word and returns its escaped form: quote, ampersand, < and > turn
// into their entities, and a space after a short word that itself follows a space turns into
// &nbsp;. Plain bytes go through at one word per cycle while out_stall is low, held in
// the holding stage and then the output stage; an escape is sent as its run of 4 to 6
// characters, during which input is still taken into the one-word holding stage.
// The output run length is what sets the throughput. Only the last six bytes can affect a
// match, so history is kept as a chain of six byte cells, cleared to zero at reset.
module html_escape_nbsp_filter_core
	import htmlesc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	logic [7:0] hist [CHAIN_LEN];
	attr_t      attr [CHAIN_LEN];
	item_t      item;
	logic       in_fire;
	logic       hold;

	assign in_fire  = in_valid && !hold;
	assign in_stall = hold;

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			htmlesc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.advance (in_fire),
				.d       (in_byte),
				.q       (hist[i]),
				.attr    (attr[i])
			);
		end else begin : g_body
			htmlesc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.advance (in_fire),
				.d       (hist[i-1]),
				.q       (hist[i]),
				.attr    (attr[i])
			);
		end
	end

	htmlesc_class u_class (
		.in_byte (in_byte),
		.attr    (attr),
		.item    (item)
	);

	htmlesc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.item      (item),
		.hold      (hold),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
